// ===== rtl/gas_pulse_counter_rate_lock_core_assert.svh =====
// Assertion macros shared by the gas pulse counter RTL.
`ifndef GAS_PULSE_COUNTER_RATE_LOCK_CORE_ASSERT_SVH
`define GAS_PULSE_COUNTER_RATE_LOCK_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define GPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked out of reset.
`define GPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GPC_ASSERT_IMP(lbl, ante, cons, msg)
`define GPC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/gpc_pkg.sv =====
// Shared types and constants of the gas pulse counter.
`default_nettype none
package gpc_pkg;

  localparam int unsigned SENSOR_W    = 6;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned VOL_W       = 48;
  localparam int unsigned CAL_W       = 32;
  localparam int unsigned PULSE_S_W   = 12;
  localparam int unsigned LIMIT_W     = 5;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CHAN_OUT_W  = 3;

  localparam logic [9:0]       MS_PER_SECOND = 10'd1000;
  localparam logic [VOL_W-1:0] VOLUME_MAX    = '1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SENSOR_POL  = 3'd0,
    CFG_MAX_PER_WIN = 3'd1,
    CFG_PULSE_SEC   = 3'd2,
    CFG_CAL_VOLUME  = 3'd3,
    CFG_VALVES_OFF  = 3'd4
  } cfg_idx_e;

  // Per-channel state that survives a clear command
  typedef struct packed {
    logic               prev_level;
    logic               valve_open;
    logic [TIME_W-1:0]  start_ms;
    logic [COUNT_W-1:0] trig_count;
    logic [VOL_W-1:0]   volume;
  } chan_state_t;

endpackage
`default_nettype wire

// ===== rtl/gpc_state_store.sv =====
// Per-channel state memory with reset and clear valid bits.
`default_nettype none
module gpc_state_store #(
  parameter int unsigned DEPTH = 6,
  parameter int unsigned AW    = 3,
  parameter int unsigned HW    = 12
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 clear_i,
  input  wire                 wr_en_i,
  input  wire  [AW-1:0]       wr_addr_i,
  input  wire gpc_pkg::chan_state_t wr_base_i,
  input  wire  [HW-1:0]       wr_hist_i,
  input  wire                 rd_en_i,
  input  wire  [AW-1:0]       rd_addr_i,
  output gpc_pkg::chan_state_t rd_base_o,
  output logic [HW-1:0]       rd_hist_o
);

  gpc_pkg::chan_state_t base_mem_q [DEPTH];
  logic [HW-1:0]        hist_mem_q [DEPTH];
  logic [DEPTH-1:0]     base_vld_q;
  logic [DEPTH-1:0]     hist_vld_q;
  gpc_pkg::chan_state_t rd_base_q;
  logic [HW-1:0]        rd_hist_q;
  logic                 rd_bv_q;
  logic                 rd_hv_q;

  // Valid bits: reset clears both, a clear command only the history part
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_vld_q <= '0;
      hist_vld_q <= '0;
      rd_bv_q    <= 1'b0;
      rd_hv_q    <= 1'b0;
    end else begin
      if (clear_i) begin
        hist_vld_q <= '0;
      end
      if (wr_en_i) begin
        base_vld_q[wr_addr_i] <= 1'b1;
        hist_vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_bv_q <= base_vld_q[rd_addr_i];
        rd_hv_q <= hist_vld_q[rd_addr_i];
      end
    end
  end

  // Storage and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      base_mem_q[wr_addr_i] <= wr_base_i;
      hist_mem_q[wr_addr_i] <= wr_hist_i;
    end
    if (rd_en_i) begin
      rd_base_q <= base_mem_q[rd_addr_i];
      rd_hist_q <= hist_mem_q[rd_addr_i];
    end
  end

  // Entries never written read as zero; the history part also reads as zero after a clear
  assign rd_base_o = rd_bv_q ? rd_base_q : '0;
  assign rd_hist_o = rd_hv_q ? rd_hist_q : '0;

endmodule
`default_nettype wire

// ===== rtl/gpc_hist_ram.sv =====
// Trigger time history memory, one write and one registered read port.
`default_nettype none
module gpc_hist_ram #(
  parameter int unsigned ENTRIES = 192,
  parameter int unsigned AW      = 8
) (
  input  wire                              clk_i,
  input  wire                              wr_en_i,
  input  wire  [AW-1:0]                    wr_addr_i,
  input  wire  [gpc_pkg::TIME_W-1:0]       wr_data_i,
  input  wire                              rd_en_i,
  input  wire  [AW-1:0]                    rd_addr_i,
  output logic [gpc_pkg::TIME_W-1:0]       rd_data_o
);

  logic [gpc_pkg::TIME_W-1:0] mem_q [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gas_pulse_counter_rate_lock_core.sv =====
// Each item taken yields one result per channel, channels in order from zero.
// Each channel runs a state read then an update, with a history read between for a count candidate.
// The update waits while the output stalls; no new item is taken until the sequencer is idle.
// A clear item returns no results.
// Reset clears control and marks all channel state as zero; no clearing pass is run.
`default_nettype none
`include "gas_pulse_counter_rate_lock_core_assert.svh"
module gas_pulse_counter_rate_lock_core #(
  parameter int unsigned CHANNELS      = 6,
  parameter int unsigned HISTORY_DEPTH = 32,
  parameter int unsigned WINDOW_MS     = 60000
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // configuration
  input  wire                                  cfg_we_i,
  input  wire  [gpc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire  [gpc_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  // input items
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire                                  cmd_i,
  input  wire  [gpc_pkg::SENSOR_W-1:0]         sensor_bits_i,
  input  wire  [gpc_pkg::TIME_W-1:0]           now_ms_i,
  // result items
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic [gpc_pkg::CHAN_OUT_W-1:0]       channel_o,
  output logic                                 level_seen_o,
  output logic                                 valve_state_o,
  output logic                                 lock_state_o,
  output logic                                 counted_o,
  output logic                                 newly_locked_o,
  output logic [gpc_pkg::COUNT_W-1:0]          trigger_total_o,
  output logic [gpc_pkg::VOL_W-1:0]            gas_total_o,
  output logic                                 last_o
);

  localparam int unsigned CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CHX_W    = (CH_W > gpc_pkg::CHAN_OUT_W) ? CH_W : gpc_pkg::CHAN_OUT_W;
  localparam int unsigned SLOT_W   = $clog2(HISTORY_DEPTH);
  localparam int unsigned FILL_W   = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned LW       = (FILL_W > 6) ? FILL_W : 6;
  localparam int unsigned HW       = 1 + FILL_W + SLOT_W;
  localparam int unsigned HIST_AW  = CH_W + SLOT_W;
  localparam int unsigned HIST_ENT = CHANNELS * (2 ** SLOT_W);
  localparam logic [CH_W-1:0]   LAST_CH = CH_W'(CHANNELS - 1);
  localparam logic [SLOT_W:0]   DEPTH_S = (SLOT_W + 1)'(HISTORY_DEPTH);
  localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(HISTORY_DEPTH);
  localparam logic [gpc_pkg::TIME_W-1:0] WINDOW = gpc_pkg::TIME_W'(WINDOW_MS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_CHECK,
    S_UPD
  } state_e;

  // History bookkeeping kept next to the channel state
  typedef struct packed {
    logic              lock;
    logic [FILL_W-1:0] fill;
    logic [SLOT_W-1:0] head;
  } hist_t;

  // Circular slot wrap for sums below twice the depth
  function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SLOT_W:0] s);
    logic [SLOT_W:0] t;
    t = (s >= DEPTH_S) ? (s - DEPTH_S) : s;
    return t[SLOT_W-1:0];
  endfunction

  // configuration
  logic                              pol_q;
  logic [gpc_pkg::LIMIT_W-1:0]       mpw_q;
  logic [gpc_pkg::PULSE_S_W-1:0]     pulse_s_q;
  logic [gpc_pkg::CAL_W-1:0]         cal_q;
  logic                              vdis_q;
  logic [gpc_pkg::TIME_W-1:0]        pulse_ms_q;

  // sequencer
  state_e                            state_q, state_d;
  logic [CH_W-1:0]                   ch_q, ch_d;
  logic                              out_valid_q, out_valid_d;
  logic [gpc_pkg::SENSOR_W-1:0]      bits_q;
  logic [gpc_pkg::TIME_W-1:0]        now_q;

  // per-channel working registers
  logic                              cur_q;
  logic                              valve_q;
  logic [gpc_pkg::TIME_W-1:0]        start_q;
  logic [gpc_pkg::COUNT_W-1:0]       count_q;
  logic [gpc_pkg::VOL_W-1:0]         vol_q;
  logic                              lock_q;
  logic [FILL_W-1:0]                 fill_q;
  logic [SLOT_W-1:0]                 head_q;
  logic                              cand_q;
  logic                              ge_q;
  logic                              lim1_q;
  logic                              exc_q;

  // combinational
  logic                              in_accept;
  logic                              out_free;
  logic                              out_load;
  logic [CHANNELS-1:0]               raw_vec;
  logic                              cur;
  gpc_pkg::chan_state_t              st_rd;
  logic [HW-1:0]                     hs_rd_bits;
  hist_t                             hs;
  logic [gpc_pkg::TIME_W-1:0]        elapsed;
  logic                              valve_after;
  logic                              cand;
  logic                              full;
  logic [SLOT_W-1:0]                 wslot;
  logic [SLOT_W-1:0]                 head_nx;
  logic [FILL_W-1:0]                 fill_nx;
  logic [LW-1:0]                     limit;
  logic [LW-1:0]                     tlog;
  logic                              ge;
  logic [SLOT_W-1:0]                 tslot;
  logic [gpc_pkg::TIME_W-1:0]        hist_rdata;
  logic                              exc_d;
  logic                              counted;
  logic                              locked_now;
  logic [gpc_pkg::VOL_W:0]           vsum;
  gpc_pkg::chan_state_t              st_wr;
  hist_t                             hs_wr;
  logic                              st_rd_en;
  logic [CH_W-1:0]                   st_rd_addr;
  logic                              st_clear;
  logic                              st_we;
  logic                              hist_we;
  logic [CHX_W-1:0]                  chx;
  logic                              out_last_d;
  logic                              chk_flag;
  logic                              chk_flags_ok;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = (state_q == S_UPD) && out_free;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pol_q      <= 1'b0;
      mpw_q      <= gpc_pkg::LIMIT_W'(29);
      pulse_s_q  <= gpc_pkg::PULSE_S_W'(1);
      cal_q      <= gpc_pkg::CAL_W'(65536);
      vdis_q     <= 1'b0;
      pulse_ms_q <= gpc_pkg::TIME_W'(1000);
    end else begin
      pulse_ms_q <= gpc_pkg::TIME_W'(pulse_s_q) * gpc_pkg::TIME_W'(gpc_pkg::MS_PER_SECOND);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          gpc_pkg::CFG_SENSOR_POL:  pol_q     <= cfg_data_i[0];
          gpc_pkg::CFG_MAX_PER_WIN: mpw_q     <= cfg_data_i[gpc_pkg::LIMIT_W-1:0];
          gpc_pkg::CFG_PULSE_SEC:   pulse_s_q <= cfg_data_i[gpc_pkg::PULSE_S_W-1:0];
          gpc_pkg::CFG_CAL_VOLUME:  cal_q     <= cfg_data_i[gpc_pkg::CAL_W-1:0];
          gpc_pkg::CFG_VALVES_OFF:  vdis_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // sensor bit per channel; channels past the sensor word read zero
  for (genvar g = 0; g < CHANNELS; g++) begin : g_raw
    if (g < gpc_pkg::SENSOR_W) begin : g_bit
      assign raw_vec[g] = bits_q[g];
    end else begin : g_zero
      assign raw_vec[g] = 1'b0;
    end
  end

  // channel evaluation on the state read back from memory
  assign hs          = hist_t'(hs_rd_bits);
  assign cur         = pol_q ? raw_vec[ch_q] : !raw_vec[ch_q];
  assign elapsed     = now_q - st_rd.start_ms;
  assign valve_after = st_rd.valve_open && (elapsed < pulse_ms_q);
  assign cand        = cur && !st_rd.prev_level && !hs.lock && !vdis_q && !valve_after;

  // circular history slot arithmetic
  assign full    = (hs.fill == DEPTH_F);
  assign wslot   = full ? hs.head
                        : wrap_slot((SLOT_W + 1)'(hs.head) + (SLOT_W + 1)'(hs.fill));
  assign head_nx = full ? wrap_slot((SLOT_W + 1)'(hs.head) + (SLOT_W + 1)'(1)) : hs.head;
  assign fill_nx = full ? hs.fill : (hs.fill + FILL_W'(1));
  assign limit   = LW'(mpw_q) + LW'(1);
  assign ge      = (LW'(fill_nx) >= limit);
  assign tlog    = LW'(fill_nx) - limit;
  assign tslot   = wrap_slot((SLOT_W + 1)'(head_nx) + (SLOT_W + 1)'(tlog));

  // rate check against the entry limit places back
  assign exc_d = ge_q && (lim1_q || ((now_q - hist_rdata) < WINDOW));

  // update and write-back
  assign counted    = cand_q && !exc_q;
  assign locked_now = cand_q && exc_q;
  assign vsum       = {1'b0, vol_q} + (gpc_pkg::VOL_W + 1)'(cal_q);

  always_comb begin
    st_wr.prev_level = cur_q;
    st_wr.valve_open = valve_q || counted;
    st_wr.start_ms   = counted ? now_q : start_q;
    st_wr.trig_count = count_q + gpc_pkg::COUNT_W'(counted);
    if (counted) begin
      st_wr.volume = vsum[gpc_pkg::VOL_W] ? gpc_pkg::VOLUME_MAX : vsum[gpc_pkg::VOL_W-1:0];
    end else begin
      st_wr.volume = vol_q;
    end
    hs_wr.lock = lock_q || locked_now;
    hs_wr.fill = fill_q;
    hs_wr.head = head_q;
  end

  // memory port control
  assign hist_we    = (state_q == S_EVAL) && cand;
  assign st_we      = out_load;
  assign st_clear   = in_accept && cmd_i;
  assign st_rd_en   = (in_accept && !cmd_i) || (out_load && (ch_q != LAST_CH));
  assign st_rd_addr = (state_q == S_IDLE) ? '0 : (ch_q + CH_W'(1));
  assign chx        = CHX_W'(ch_q);
  assign out_last_d = (ch_q == LAST_CH);

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_accept && !cmd_i) begin
          state_d = S_EVAL;
          ch_d    = '0;
        end
      end
      S_EVAL: begin
        state_d = cand ? S_CHECK : S_UPD;
      end
      S_CHECK: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (out_last_d) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_EVAL;
            ch_d    = ch_q + CH_W'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      bits_q <= sensor_bits_i;
      now_q  <= now_ms_i;
    end
    if (state_q == S_EVAL) begin
      cur_q   <= cur;
      valve_q <= valve_after;
      start_q <= st_rd.start_ms;
      count_q <= st_rd.trig_count;
      vol_q   <= st_rd.volume;
      lock_q  <= hs.lock;
      fill_q  <= cand ? fill_nx : hs.fill;
      head_q  <= cand ? head_nx : hs.head;
      cand_q  <= cand;
      ge_q    <= ge;
      lim1_q  <= (mpw_q == '0);
      exc_q   <= 1'b0;
    end
    if (state_q == S_CHECK) begin
      exc_q <= exc_d;
    end
    if (out_load) begin
      channel_o       <= chx[gpc_pkg::CHAN_OUT_W-1:0];
      level_seen_o    <= cur_q;
      valve_state_o   <= st_wr.valve_open;
      lock_state_o    <= hs_wr.lock;
      counted_o       <= counted;
      newly_locked_o  <= locked_now;
      trigger_total_o <= st_wr.trig_count;
      gas_total_o     <= st_wr.volume;
      last_o          <= out_last_d;
    end
  end

  gpc_state_store #(
    .DEPTH (CHANNELS),
    .AW    (CH_W),
    .HW    (HW)
  ) u_state (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (st_clear),
    .wr_en_i   (st_we),
    .wr_addr_i (ch_q),
    .wr_base_i (st_wr),
    .wr_hist_i (HW'(hs_wr)),
    .rd_en_i   (st_rd_en),
    .rd_addr_i (st_rd_addr),
    .rd_base_o (st_rd),
    .rd_hist_o (hs_rd_bits)
  );

  gpc_hist_ram #(
    .ENTRIES (HIST_ENT),
    .AW      (HIST_AW)
  ) u_hist (
    .clk_i     (clk_i),
    .wr_en_i   (hist_we),
    .wr_addr_i ({ch_q, wslot}),
    .wr_data_i (now_q),
    .rd_en_i   (hist_we),
    .rd_addr_i ({ch_q, tslot}),
    .rd_data_o (hist_rdata)
  );

  // flag consistency terms for the checks
  assign chk_flag     = out_valid_o && (counted_o || newly_locked_o);
  assign chk_flags_ok = (counted_o != newly_locked_o) && (valve_state_o == counted_o)
                        && (lock_state_o == newly_locked_o);

  // checks
  `GPC_ASSERT_IMP(a_no_overwrite, out_valid_q && out_stall_i, !out_load, "result overwritten")
  `GPC_ASSERT_NXT(a_hist_then_check, hist_we, state_q == S_CHECK, "no check after history write")
  `GPC_ASSERT_NXT(a_last_to_idle, out_load && out_last_d, state_q == S_IDLE, "no return to idle")
  `GPC_ASSERT_IMP(a_count_or_lock, chk_flag, chk_flags_ok, "count and lock flags disagree")

endmodule
`default_nettype wire
